>>> src/dsplit_pkg.sv
// Package for the delimiter splitter: sizes, register indexes and the
// request, result and cell control types used by the modules.
// No dependencies.
package dsplit_pkg;

   localparam int SEP_MAX    = 8;
   localparam int MAX_RES    = SEP_MAX + 1;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = $clog2(SEP_MAX);
   localparam int LEN_W      = $clog2(MAX_RES + 1);
   localparam int SEP_LEN_W  = 4;
   localparam int CSR_DATA_W = SEP_MAX * BYTE_W;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SEP_LEN   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_BYTES = 1'd1;

   localparam logic [SEP_LEN_W-1:0]  SEP_LEN_RST   = 4'd1;
   localparam logic [CSR_DATA_W-1:0] SEP_BYTES_RST = 64'd32;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              has_byte;
      logic              end_of_string;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              piece_end;
      logic              last_in_run;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } pend_entry_type;

   typedef struct packed {
      logic              load;
      logic              use_fresh;
      logic [BYTE_W-1:0] fresh_byte;
      logic [BYTE_W-1:0] next_byte;
   } win_ctl_type;

   typedef struct packed {
      logic load;
      logic shift;
   } pend_ctl_type;

endpackage

>>> src/dsplit_win_cell.sv
// One cell of the held window: stores a byte and compares the byte it
// presents against every separator byte. Depends on dsplit_pkg.
module dsplit_win_cell (
   input  logic                                  clock,
   input  dsplit_pkg::win_ctl_type               ctl,
   input  logic [dsplit_pkg::CSR_DATA_W-1:0]     sep_bytes,
   output logic [dsplit_pkg::BYTE_W-1:0]         ext_byte,
   output logic [dsplit_pkg::SEP_MAX-1:0]        eq
);

   logic [dsplit_pkg::BYTE_W-1:0] byte_ff;
   logic [dsplit_pkg::BYTE_W-1:0] byte_in;

   assign ext_byte = ctl.use_fresh ? ctl.fresh_byte : byte_ff;
   assign byte_in  = ctl.load ? ctl.next_byte : byte_ff;

   always_comb begin
      for (int j = 0; j < dsplit_pkg::SEP_MAX; j++) begin
         eq[j] = (ext_byte == sep_bytes[j * dsplit_pkg::BYTE_W +: dsplit_pkg::BYTE_W]);
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

>>> src/dsplit_pend_cell.sv
// One cell of the pending result row: loads a fresh result or takes its
// neighbour's entry as the row moves towards the output. Depends on dsplit_pkg.
module dsplit_pend_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  dsplit_pkg::pend_ctl_type   ctl,
   input  dsplit_pkg::pend_entry_type load_entry,
   input  dsplit_pkg::pend_entry_type nbr_entry,
   output dsplit_pkg::pend_entry_type entry
);

   logic                valid_ff;
   logic                valid_in;
   dsplit_pkg::rsp_type data_ff;
   dsplit_pkg::rsp_type data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.load) begin
         valid_in = load_entry.valid;
         data_in  = load_entry.data;
      end else if (ctl.shift) begin
         valid_in = nbr_entry.valid;
         data_in  = nbr_entry.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign entry.valid = valid_ff;
   assign entry.data  = data_ff;

endmodule

>>> src/delimiter_split_unit.sv
// Delimiter splitter top level: held window cells, shift selection and the
// pending result row in front of the output register.
// Depends on dsplit_pkg, dsplit_win_cell and dsplit_pend_cell.
//
// The block takes a string one byte per request and splits it on a separator
// of up to eight bytes set through the register port (length at index 0,
// bytes at index 1, first byte lowest; one space after reset). Bytes that may
// begin a separator are held in a row of eight window cells which compare
// against all separator bytes at once, so a request is taken every cycle
// while each one gives at most one result and the result side keeps up. A
// request that gives n results, up to nine, passes them one by one through the
// single output register: its results wait in a nine-entry pending row, and
// the input stalls until that row is empty. Results of one request are
// flagged last_in_run on the final one. There is no clearing pass after reset.
module delimiter_split_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dsplit_pkg::req_type                   req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dsplit_pkg::rsp_type                   rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [dsplit_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dsplit_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SEP_MAX = dsplit_pkg::SEP_MAX;
   localparam int MAX_RES = dsplit_pkg::MAX_RES;
   localparam int LEN_W   = dsplit_pkg::LEN_W;
   localparam int CNT_W   = dsplit_pkg::CNT_W;
   localparam int BYTE_W  = dsplit_pkg::BYTE_W;

   logic [dsplit_pkg::SEP_LEN_W-1:0]  sep_len_ff;
   logic [dsplit_pkg::SEP_LEN_W-1:0]  sep_len_in;
   logic [dsplit_pkg::CSR_DATA_W-1:0] sep_bytes_ff;
   logic [dsplit_pkg::CSR_DATA_W-1:0] sep_bytes_in;
   logic [CNT_W-1:0]                  held_count_ff;
   logic [CNT_W-1:0]                  held_count_in;
   logic                              piece_open_ff;
   logic                              piece_open_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   dsplit_pkg::rsp_type               rsp_data_ff;
   dsplit_pkg::rsp_type               rsp_data_in;

   logic [LEN_W-1:0]   eff_len;
   logic               req_fire;
   logic               out_free;
   logic [LEN_W-1:0]   m;
   logic [LEN_W-1:0]   shift;
   logic [LEN_W-1:0]   rem;
   logic [LEN_W-1:0]   nb;
   logic [LEN_W-1:0]   nres;
   logic               match;
   logic               end_flag;
   logic [MAX_RES-1:0] ok;
   logic [MAX_RES-1:0] pend_vld;

   logic [BYTE_W-1:0]  ext     [SEP_MAX];
   logic [BYTE_W-1:0]  shifted [SEP_MAX];
   logic [SEP_MAX-1:0] eq      [SEP_MAX];

   dsplit_pkg::win_ctl_type    win_ctl [SEP_MAX];
   dsplit_pkg::pend_ctl_type   pend_ctl;
   dsplit_pkg::pend_entry_type res     [MAX_RES + 1];
   dsplit_pkg::pend_entry_type pend    [MAX_RES + 1];
   dsplit_pkg::pend_entry_type pend_load [MAX_RES];

   // Configuration registers.
   always_comb begin
      sep_len_in   = sep_len_ff;
      sep_bytes_in = sep_bytes_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dsplit_pkg::CSR_SEP_LEN:   sep_len_in   = csr_wdata[dsplit_pkg::SEP_LEN_W-1:0];
            dsplit_pkg::CSR_SEP_BYTES: sep_bytes_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign eff_len = (sep_len_ff > dsplit_pkg::SEP_LEN_W'(SEP_MAX)) ?
                    LEN_W'(SEP_MAX) : LEN_W'(sep_len_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend[0].valid;
   assign req_fire  = req_valid && !req_stall;

   assign m = LEN_W'(held_count_ff) + LEN_W'(req_data.has_byte);

   // Window cells.
   for (genvar i = 0; i < SEP_MAX; i++) begin : g_win
      assign win_ctl[i].load       = req_fire && req_data.has_byte;
      assign win_ctl[i].use_fresh  = (LEN_W'(i) == LEN_W'(held_count_ff));
      assign win_ctl[i].fresh_byte = req_data.in_byte;
      assign win_ctl[i].next_byte  = shifted[i];

      dsplit_win_cell u_cell (
         .clock     (clock),
         .ctl       (win_ctl[i]),
         .sep_bytes (sep_bytes_ff),
         .ext_byte  (ext[i]),
         .eq        (eq[i])
      );
   end

   // A shift is usable when the bytes left after it still begin the separator.
   always_comb begin
      for (int s = 0; s < MAX_RES; s++) begin
         ok[s] = (LEN_W'(s) <= m) && ((m - LEN_W'(s)) <= eff_len);
         for (int j = 0; j < SEP_MAX - s; j++) begin
            if ((LEN_W'(s + j) < m) && !eq[s + j][j]) begin
               ok[s] = 1'b0;
            end
         end
      end
      shift = m;
      for (int s = MAX_RES - 1; s >= 0; s--) begin
         if (ok[s]) begin
            shift = LEN_W'(s);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SEP_MAX; i++) begin
         shifted[i] = '0;
         for (int t = 0; t < SEP_MAX; t++) begin
            if (LEN_W'(t) == LEN_W'(i) + shift) begin
               shifted[i] = ext[t];
            end
         end
      end
   end

   assign rem   = m - shift;
   assign match = req_data.has_byte && (rem == eff_len);

   always_comb begin
      if (!req_data.has_byte && !req_data.end_of_string) begin
         nb = '0;
      end else if (req_data.end_of_string && !match) begin
         nb = m;
      end else begin
         nb = shift;
      end
      end_flag = match || (req_data.end_of_string && (piece_open_ff || (nb != '0)));
      nres     = nb + LEN_W'(end_flag);
   end

   // Results of the current request, in order.
   always_comb begin
      for (int i = 0; i < SEP_MAX; i++) begin
         res[i].valid            = (LEN_W'(i) < nres);
         res[i].data.piece_end   = (LEN_W'(i) == nb);
         res[i].data.out_byte    = (LEN_W'(i) == nb) ? '0 : ext[i];
         res[i].data.last_in_run = (LEN_W'(i) + LEN_W'(1) == nres);
      end
      res[SEP_MAX].valid            = (LEN_W'(SEP_MAX) < nres);
      res[SEP_MAX].data.piece_end   = 1'b1;
      res[SEP_MAX].data.out_byte    = '0;
      res[SEP_MAX].data.last_in_run = 1'b1;
      res[MAX_RES]                  = '0;
   end

   // Pending row.
   assign pend_ctl.load  = req_fire;
   assign pend_ctl.shift = out_free;
   assign pend[MAX_RES]  = '0;

   for (genvar j = 0; j < MAX_RES; j++) begin : g_pend
      assign pend_load[j] = out_free ? res[j + 1] : res[j];
      assign pend_vld[j]  = pend[j].valid;

      dsplit_pend_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (pend_ctl),
         .load_entry (pend_load[j]),
         .nbr_entry  (pend[j + 1]),
         .entry      (pend[j])
      );
   end

   // Output register and window state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         if (req_fire) begin
            rsp_valid_in = res[0].valid;
            rsp_data_in  = res[0].data;
         end else begin
            rsp_valid_in = pend[0].valid;
            rsp_data_in  = pend[0].data;
         end
      end

      held_count_in = held_count_ff;
      piece_open_in = piece_open_ff;
      if (req_fire) begin
         if (req_data.end_of_string || match) begin
            held_count_in = '0;
            piece_open_in = 1'b0;
         end else if (req_data.has_byte) begin
            held_count_in = rem[CNT_W-1:0];
            piece_open_in = piece_open_ff || (shift != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_len_ff    <= dsplit_pkg::SEP_LEN_RST;
         sep_bytes_ff  <= dsplit_pkg::SEP_BYTES_RST;
         held_count_ff <= '0;
         piece_open_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sep_len_ff    <= sep_len_in;
         sep_bytes_ff  <= sep_bytes_in;
         held_count_ff <= held_count_in;
         piece_open_ff <= piece_open_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pend_packed: assert property (@(posedge clock) disable iff (reset)
      ((pend_vld >> 1) & ~pend_vld) == '0)
      else $error("Pending row has a gap.");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last_in_run |-> pend[0].valid)
      else $error("Result is not last but nothing of its request is pending.");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.end_of_string |=> (held_count_ff == '0) && !piece_open_ff)
      else $error("End of string left held bytes or an open piece.");

   a_end_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.piece_end |-> (rsp_data_ff.out_byte == '0))
      else $error("Piece end carries a byte.");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for delimiter_split_unit: directed strings, then random strings
// under several separator settings and idle patterns, checked against a built-in predictor.
// Depends on dsplit_pkg and the delimiter_split_unit RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEP_MAX    = dsplit_pkg::SEP_MAX;
   localparam int BYTE_W     = dsplit_pkg::BYTE_W;
   localparam int SEP_LEN_W  = dsplit_pkg::SEP_LEN_W;
   localparam int CSR_IDX_W  = dsplit_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = dsplit_pkg::CSR_DATA_W;

   localparam int SETTLE_CYCLES    = 24;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int SETTING_ITEMS    = 13;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   dsplit_pkg::req_type   req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   dsplit_pkg::rsp_type   rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = dsplit_pkg::CSR_SEP_LEN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: separator settings, held bytes and whether a piece has data.
   logic [SEP_LEN_W-1:0]  cfg_sep_len;
   logic [CSR_DATA_W-1:0] cfg_sep_bytes;
   logic [BYTE_W-1:0]     win_bytes [SEP_MAX];
   int                    win_count;
   logic                  piece_busy;
   dsplit_pkg::rsp_type   pieces_due [$];
   dsplit_pkg::rsp_type   piece_want;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int string_items  = 0;
   int mismatches    = 0;

   delimiter_split_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400us;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int sep_span();
      return (cfg_sep_len > SEP_MAX) ? SEP_MAX : int'(cfg_sep_len);
   endfunction

   function automatic logic window_is_prefix(input int k, input int span);
      if (k > span)
         return 1'b0;
      for (int i = 0; i < k; i++)
         if (win_bytes[i] !== cfg_sep_bytes[8*i +: 8])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic dsplit_pkg::rsp_type split_piece(input logic [BYTE_W-1:0] b,
                                                       input logic closes);
      dsplit_pkg::rsp_type r;
      r.out_byte    = closes ? '0 : b;
      r.piece_end   = closes;
      r.last_in_run = 1'b0;
      return r;
   endfunction

   function automatic void split_step(input dsplit_pkg::req_type r);
      dsplit_pkg::rsp_type outs [$];
      int      span;
      int      k;
      span = sep_span();
      k    = (win_count > SEP_MAX - 1) ? SEP_MAX - 1 : win_count;
      if (r.has_byte) begin
         win_bytes[k] = r.in_byte;
         k++;
         while (k > 0 && !window_is_prefix(k, span)) begin
            outs.push_back(split_piece(win_bytes[0], 1'b0));
            piece_busy = 1'b1;
            for (int i = 0; i < k - 1; i++)
               win_bytes[i] = win_bytes[i+1];
            k--;
         end
         if (k == span) begin
            outs.push_back(split_piece('0, 1'b1));
            piece_busy = 1'b0;
            k = 0;
         end
      end
      if (r.end_of_string) begin
         for (int i = 0; i < k; i++) begin
            outs.push_back(split_piece(win_bytes[i], 1'b0));
            piece_busy = 1'b1;
         end
         k = 0;
         if (piece_busy)
            outs.push_back(split_piece('0, 1'b1));
         piece_busy = 1'b0;
      end
      win_count = k;
      if (outs.size() > 0)
         outs[outs.size()-1].last_in_run = 1'b1;
      foreach (outs[i])
         pieces_due.push_back(outs[i]);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         split_step(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pieces_due.size() == 0) begin
            $display("%0t: unexpected result: byte %02h end %0b last %0b", $time,
                     rsp_data.out_byte, rsp_data.piece_end, rsp_data.last_in_run);
            mismatches++;
         end else begin
            piece_want = pieces_due.pop_front();
            if (rsp_data.out_byte !== piece_want.out_byte ||
                rsp_data.piece_end !== piece_want.piece_end ||
                rsp_data.last_in_run !== piece_want.last_in_run) begin
               $display("%0t: mismatch: expected byte %02h end %0b last %0b,", $time,
                        piece_want.out_byte, piece_want.piece_end, piece_want.last_in_run);
               $display("%0t:           got byte %02h end %0b last %0b", $time,
                        rsp_data.out_byte, rsp_data.piece_end, rsp_data.last_in_run);
               mismatches++;
            end
         end
      end
   end

   // The receiver stalls at random, or for a long stretch when the test asks for one.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= LONG_HOLD_CYCLES - 1;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic send_request(input logic [BYTE_W-1:0] b, input logic has, input logic eos);
      dsplit_pkg::req_type r;
      r.in_byte       = b;
      r.has_byte      = has;
      r.end_of_string = eos;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
      if (has || eos)
         string_items++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pieces_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == dsplit_pkg::CSR_SEP_LEN)
         cfg_sep_len = data[SEP_LEN_W-1:0];
      else
         cfg_sep_bytes = data;
   endtask

   function automatic logic [CSR_DATA_W-1:0] len_word(input logic [SEP_LEN_W-1:0] n);
      logic [CSR_DATA_W-1:0] w;
      w = {$urandom, $urandom};
      w[SEP_LEN_W-1:0] = n;
      return w;
   endfunction

   task automatic set_separator(input logic [SEP_LEN_W-1:0] n, input logic [CSR_DATA_W-1:0] seps);
      csr_write(dsplit_pkg::CSR_SEP_LEN, len_word(n));
      csr_write(dsplit_pkg::CSR_SEP_BYTES, seps);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_separator();
      logic [CSR_DATA_W-1:0] seps;
      seps = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1)
         for (int i = 0; i < SEP_MAX; i++)
            case ($urandom_range(0, 3))
               0:       seps[8*i +: 8] = 8'h20;
               1:       seps[8*i +: 8] = 8'h2C;
               2:       seps[8*i +: 8] = 8'h00;
               default: seps[8*i +: 8] = 8'hFF;
            endcase
      return seps;
   endfunction

   function automatic logic [SEP_LEN_W-1:0] planned_length(input int slot);
      case (slot % 8)
         0:       return 4'd0;
         1:       return 4'd1;
         2:       return 4'd8;
         3:       return 4'd15;
         4:       return 4'd2;
         5:       return 4'd3;
         6:       return 4'd9;
         default: return 4'd5;
      endcase
   endfunction

   // Strings are built from separator copies, separator bytes and random bytes so that
   // full, partial and overlapping matches all occur.
   task automatic send_random_string();
      logic [BYTE_W-1:0] text [$];
      int                span;
      int                pick;
      int                idx;
      logic              end_on_byte;
      span        = sep_span();
      end_on_byte = ($urandom_range(0, 1) == 1);
      repeat ($urandom_range(0, 12)) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            for (int i = 0; i < span; i++)
               text.push_back(cfg_sep_bytes[8*i +: 8]);
         end else if (pick < 55 && span > 0) begin
            idx = $urandom_range(0, span - 1);
            text.push_back(cfg_sep_bytes[8*idx +: 8]);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      foreach (text[i])
         send_request(text[i], 1'b1, end_on_byte && (i == text.size() - 1));
      if (!end_on_byte || text.size() == 0)
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic test_default_space();
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h20, 1'b1, 1'b0);
      send_request(8'h20, 1'b1, 1'b0);
      send_request(8'h5A, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hA5, 1'b0, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_multibyte_separator();
      set_separator(4'd3, 64'h63_62_61);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b0);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_zero_length();
      set_separator(4'd0, {$urandom, $urandom});
      send_request(8'h78, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_long_separator();
      set_separator(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
      repeat (SEP_MAX - 1) send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_separator_change();
      set_separator(4'd4, 64'h64_63_62_61);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b0);
      wait_drained();
      csr_write(dsplit_pkg::CSR_SEP_LEN, len_word(4'd0));
      send_request(8'h71, 1'b1, 1'b0);
      wait_drained();
      csr_write(dsplit_pkg::CSR_SEP_LEN, len_word(4'd4));
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      wait_drained();
      set_separator(4'd2, 64'h78_62);
      send_request(8'h78, 1'b1, 1'b1);
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so results
   // wait in the pending row and the input is stalled.
   task automatic test_output_hold();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_separator(4'd1, 64'h20);
      hold_requests++;
      repeat (40)
         send_request(($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(0, 255)),
                      1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_strings(input int send_pct, input int recv_pct, input int phase);
      int first;
      req_idle_pct  = send_pct;
      rsp_stall_pct = recv_pct;
      for (int s = 0; s < 4; s++) begin
         wait_drained();
         set_separator(planned_length(phase * 4 + s), random_separator());
         first = string_items;
         while (string_items - first < SETTING_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
               send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            else
               send_random_string();
         end
      end
      wait_drained();
   endtask

   initial begin
      cfg_sep_len   = dsplit_pkg::SEP_LEN_RST;
      cfg_sep_bytes = dsplit_pkg::SEP_BYTES_RST;
      foreach (win_bytes[i])
         win_bytes[i] = '0;
      win_count     = 0;
      piece_busy    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_pct  = 26;
      rsp_stall_pct = 84;
      test_default_space();
      test_multibyte_separator();
      test_zero_length();
      test_long_separator();
      test_separator_change();
      test_output_hold();
      test_random_strings(26, 84, 0);
      test_random_strings(84, 26, 1);
      test_random_strings(0, 0, 2);
      wait_drained();
      if (mismatches == 0 && pieces_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
